@@ src/sprite_cull_and_key_sort_assert.svh @@
// Assertion macros for the sprite cull and key sort block
`ifndef SPRITE_CULL_AND_KEY_SORT_ASSERT_SVH
`define SPRITE_CULL_AND_KEY_SORT_ASSERT_SVH
// implication checked every clock outside reset
`define SCKS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define SCKS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ src/scks_pkg.sv @@
// -----------------------------------------------------------------------------
// scks_pkg
// Shared constants, types and float key helper for the sprite cull/sort block.
// -----------------------------------------------------------------------------
package scks_pkg;
  localparam int Capacity  = 64;
  localparam int ChunkSize = 16;
  localparam int IdxW      = $clog2(Capacity);
  localparam int CntW      = $clog2(Capacity + 1);
  // sort key: layer, policy key, index, generation, ordinal
  localparam int KeyW      = 16 + 4 * 32;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrView     = 3'd1;
  localparam logic [2:0] ErrNonfin   = 3'd2;
  localparam logic [2:0] ErrBounds   = 3'd3;
  localparam logic [2:0] ErrOverflow = 3'd4;

  localparam logic [2:0] RegPolicy = 3'd0;
  localparam logic [2:0] RegMinX   = 3'd1;
  localparam logic [2:0] RegMinY   = 3'd2;
  localparam logic [2:0] RegMaxX   = 3'd3;
  localparam logic [2:0] RegMaxY   = 3'd4;

  localparam logic [1:0] PolDepth = 2'd0;
  localparam logic [1:0] PolPivot = 2'd1;
  localparam logic [1:0] PolDecl  = 2'd2;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_INIT  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_CMP   = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_WAIT  = 6'b100000
  } state_e;

  // comparator request between the sequencer and the shared compare unit
  typedef struct packed {
    logic [KeyW-1:0] a;
    logic [KeyW-1:0] b;
  } cmp_req_t;

  function automatic logic is_finite(input logic [31:0] b);
    return b[30:23] != 8'hFF;
  endfunction

  function automatic logic [31:0] float_key(input logic [31:0] b);
    logic [31:0] v;
    v = (b[30:0] == 31'd0) ? 32'd0 : b;
    return v[31] ? ~v : (v ^ 32'h8000_0000);
  endfunction

  function automatic logic fle(input logic [31:0] a, input logic [31:0] b);
    return float_key(a) <= float_key(b);
  endfunction
endpackage

@@ src/scks_cmp.sv @@
// -----------------------------------------------------------------------------
// scks_cmp
// Shared key comparator: one wide compare of two packed sort keys, registered.
// -----------------------------------------------------------------------------
module scks_cmp (
  input  logic                clk_i,
  input  scks_pkg::cmp_req_t  req_i,
  output logic                lt_o
);
  logic lt_q;
  // packed key order matches field priority, so one compare does it
  always_ff @(posedge clk_i) begin
    lt_q <= req_i.a < req_i.b;
  end
  assign lt_o = lt_q;
endmodule

@@ src/sprite_cull_and_key_sort.sv @@
// -----------------------------------------------------------------------------
// sprite_cull_and_key_sort
// Culls sprite records against a view window and sorts the kept ones.
// -----------------------------------------------------------------------------
// Records are taken one per cycle while the block is loading and written to a key
// memory. After the final record the block runs an insertion sort over an order
// memory with one shared comparator: each compare steps through order read, key
// read, compare and act, and each record first fetches its own key (ST_INIT,
// ST_READ). Each emitted word then steps through order read, slot read and present,
// plus any output stall. No record is accepted while the sort and output run.
module sprite_cull_and_key_sort (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] layer_number_i,
  input  logic [31:0] depth_bits_i,
  input  logic [31:0] pivot_y_bits_i,
  input  logic [31:0] declaration_number_i,
  input  logic [31:0] entity_index_i,
  input  logic [31:0] entity_generation_i,
  input  logic [31:0] source_number_i,
  input  logic [31:0] canvas_min_x_i,
  input  logic [31:0] canvas_min_y_i,
  input  logic [31:0] canvas_max_x_i,
  input  logic [31:0] canvas_max_y_i,
  input  logic        final_record_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        has_item_o,
  output logic [5:0]  slot_index_o,
  output logic [5:0]  chunk_number_o,
  output logic        chunk_first_o,
  output logic [2:0]  error_code_o,
  output logic [6:0]  visible_total_o,
  output logic [6:0]  logical_total_o,
  output logic        run_end_o
);
  localparam int IW = scks_pkg::IdxW;
  localparam int CW = scks_pkg::CntW;
  localparam int KW = scks_pkg::KeyW;

  // configuration registers
  logic [1:0]  policy_q;
  logic [31:0] vminx_q, vminy_q, vmaxx_q, vmaxy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= '0; vminx_q <= '0; vminy_q <= '0; vmaxx_q <= '0; vmaxy_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scks_pkg::RegPolicy: policy_q <= cfg_data_i[1:0];
        scks_pkg::RegMinX:   vminx_q  <= cfg_data_i;
        scks_pkg::RegMinY:   vminy_q  <= cfg_data_i;
        scks_pkg::RegMaxX:   vmaxx_q  <= cfg_data_i;
        scks_pkg::RegMaxY:   vmaxy_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  scks_pkg::state_e state_q, state_d;
  logic [CW-1:0] kept_q, recv_q;
  logic [2:0]    err_q;
  logic [CW-1:0] i_q, j_q;     // outer and inner sort indexes
  logic [IW-1:0] cur_q;        // entry being inserted
  logic [KW-1:0] cur_key_q;
  logic          out_valid_q;

  // memories: key+slot store, and sort order
  logic [KW-1:0] key_mem [scks_pkg::Capacity];
  logic [IW-1:0] slot_mem [scks_pkg::Capacity];
  logic [IW-1:0] ord_mem [scks_pkg::Capacity];

  logic acc;
  assign in_stall_o = (state_q != scks_pkg::ST_LOAD);
  assign acc = in_valid_i && !in_stall_o;

  // per-record checks
  logic rec_nf, rec_bb, rec_vis;
  logic [31:0] pkey;
  always_comb begin
    rec_nf = !scks_pkg::is_finite(depth_bits_i) || !scks_pkg::is_finite(pivot_y_bits_i);
    rec_bb = !scks_pkg::is_finite(canvas_min_x_i) || !scks_pkg::is_finite(canvas_min_y_i) ||
             !scks_pkg::is_finite(canvas_max_x_i) || !scks_pkg::is_finite(canvas_max_y_i) ||
             !scks_pkg::fle(canvas_min_x_i, canvas_max_x_i) ||
             !scks_pkg::fle(canvas_min_y_i, canvas_max_y_i);
    rec_vis = scks_pkg::fle(vminx_q, canvas_max_x_i) && scks_pkg::fle(canvas_min_x_i, vmaxx_q) &&
              scks_pkg::fle(vminy_q, canvas_max_y_i) && scks_pkg::fle(canvas_min_y_i, vmaxy_q);
    case (policy_q)
      scks_pkg::PolDepth: pkey = scks_pkg::float_key(depth_bits_i);
      scks_pkg::PolPivot: pkey = ~scks_pkg::float_key(pivot_y_bits_i);
      scks_pkg::PolDecl:  pkey = declaration_number_i;
      default:            pkey = '0;
    endcase
  end

  logic view_bad;
  assign view_bad = !scks_pkg::is_finite(vminx_q) || !scks_pkg::is_finite(vminy_q) ||
                    !scks_pkg::is_finite(vmaxx_q) || !scks_pkg::is_finite(vmaxy_q) ||
                    !scks_pkg::fle(vminx_q, vmaxx_q) || !scks_pkg::fle(vminy_q, vmaxy_q);

  logic store_en;
  assign store_en = acc && (recv_q < CW'(scks_pkg::Capacity)) && !rec_nf && !rec_bb &&
                    rec_vis;

  // registered memory reads
  logic [IW-1:0] ord_rd_q, slot_rd_q;
  logic [KW-1:0] key_rd_q;
  logic [IW-1:0] ord_wa;
  logic [IW-1:0] ord_wd;
  logic          ord_we;
  logic [IW-1:0] ord_ra, key_ra;
  logic          key_we;
  logic [KW-1:0] key_wd;
  logic [IW-1:0] key_wa;
  assign key_we = store_en;
  assign key_wa = kept_q[IW-1:0];
  assign key_wd = {layer_number_i, pkey, entity_index_i, entity_generation_i,
                   source_number_i};
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa]  <= key_wd;
      slot_mem[key_wa] <= recv_q[IW-1:0];
    end
    key_rd_q  <= key_mem[key_ra];
    slot_rd_q <= slot_mem[key_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_rd_q <= ord_mem[ord_ra];
  end

  // shared comparator: current key against order[j-1]
  scks_pkg::cmp_req_t req;
  logic lt;
  assign req.a = cur_key_q;
  assign req.b = key_rd_q;
  scks_cmp u_cmp (.clk_i(clk_i), .req_i(req), .lt_o(lt));

  // phase within the compare: 0 order read issued, 1 key read issued, 2 compare, 3 act
  logic [1:0] ph_q, ph_d;
  logic [CW-1:0] kept_d, recv_d, i_d, j_d;
  logic [2:0] err_d;
  logic [IW-1:0] cur_d;
  logic [KW-1:0] cur_key_d;
  logic out_valid_d;
  logic out_has_d, out_first_d, out_end_d;
  logic [5:0] out_chunk_d;
  logic [2:0] out_err_d;
  logic [6:0] out_vis_d, out_log_d;
  logic has_q, first_q, end_q;
  logic [5:0] chunk_q;
  logic [2:0] oerr_q;
  logic [6:0] vis_q, log_q;
  logic       slot_sel_q, slot_sel_d;

  always_comb begin
    state_d = state_q; kept_d = kept_q; recv_d = recv_q; err_d = err_q;
    i_d = i_q; j_d = j_q; cur_d = cur_q; cur_key_d = cur_key_q; ph_d = ph_q;
    out_valid_d = out_valid_q; out_has_d = has_q; out_first_d = first_q;
    out_end_d = end_q; out_chunk_d = chunk_q; out_err_d = oerr_q;
    out_vis_d = vis_q; out_log_d = log_q; slot_sel_d = slot_sel_q;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
    ord_ra = IW'(j_q - CW'(1)); key_ra = ord_rd_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      scks_pkg::ST_LOAD: begin
        if (acc) begin
          if (recv_q >= CW'(scks_pkg::Capacity)) begin
            if (err_d == scks_pkg::ErrNone) err_d = scks_pkg::ErrOverflow;
          end else if (rec_nf) begin
            if (err_d == scks_pkg::ErrNone) err_d = scks_pkg::ErrNonfin;
          end else if (rec_bb) begin
            if (err_d == scks_pkg::ErrNone) err_d = scks_pkg::ErrBounds;
          end else begin
            recv_d = recv_q + CW'(1);
            if (rec_vis) kept_d = kept_q + CW'(1);
          end
          if (final_record_i) begin
            if (view_bad) err_d = scks_pkg::ErrView;
            if (err_d != scks_pkg::ErrNone || kept_d == '0) begin
              out_valid_d = 1'b1; out_has_d = 1'b0; out_first_d = 1'b0;
              out_end_d = 1'b1; out_chunk_d = '0; out_err_d = err_d;
              out_vis_d = '0; slot_sel_d = 1'b0;
              out_log_d = (err_d != scks_pkg::ErrNone) ? 7'd0 : 7'(recv_d);
              kept_d = '0; recv_d = '0; err_d = scks_pkg::ErrNone;
              state_d = scks_pkg::ST_WAIT;
            end else begin
              i_d = '0; state_d = scks_pkg::ST_INIT;
            end
          end
        end
      end
      scks_pkg::ST_INIT: begin
        // start inserting entry i and fetch its key, or go on to emit once all are placed
        if (i_q == kept_q) begin
          i_d = '0; ph_d = 2'd0; state_d = scks_pkg::ST_EMIT;
        end else begin
          key_ra = i_q[IW-1:0];
          cur_d = i_q[IW-1:0]; j_d = i_q; ph_d = 2'd0;
          state_d = scks_pkg::ST_READ;
        end
      end
      scks_pkg::ST_READ: begin
        // on entry from ST_INIT, cur key is on the read port this cycle
        cur_key_d = key_rd_q;
        if (j_q == '0) begin
          ord_we = 1'b1; ord_wa = '0; ord_wd = cur_q;
          i_d = i_q + CW'(1); state_d = scks_pkg::ST_INIT;
        end else begin
          ph_d = 2'd0; state_d = scks_pkg::ST_CMP;
        end
      end
      scks_pkg::ST_CMP: begin
        // ph 0: order[j-1] read, ph 1: key read, ph 2: compare registered, ph 3: act
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          if (lt) begin
            ord_we = 1'b1; ord_wa = j_q[IW-1:0]; ord_wd = key_ra;
            j_d = j_q - CW'(1);
            ph_d = 2'd0;
            if (j_q == CW'(1)) begin
              // reached the front
              ph_d = 2'd0;
            end
          end else begin
            ord_we = 1'b1; ord_wa = j_q[IW-1:0]; ord_wd = cur_q;
            i_d = i_q + CW'(1); state_d = scks_pkg::ST_INIT;
          end
          if (lt && j_q == CW'(1)) begin
            state_d = scks_pkg::ST_READ;
          end
        end
        // hold order address while key of order[j-1] is read
        if (ph_q != 2'd0) key_ra = ord_rd_q;
      end
      scks_pkg::ST_EMIT: begin
        // ph 0: order read, ph 1: slot read, ph 2: present
        ord_ra = i_q[IW-1:0];
        if (ph_q == 2'd2) begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_d = 1'b1; out_has_d = 1'b1; slot_sel_d = 1'b1;
            out_chunk_d = 6'(i_q / CW'(scks_pkg::ChunkSize));
            out_first_d = (i_q % CW'(scks_pkg::ChunkSize)) == '0;
            out_err_d = scks_pkg::ErrNone;
            out_vis_d = 7'(kept_q); out_log_d = 7'(recv_q);
            out_end_d = (i_q + CW'(1)) == kept_q;
            ph_d = 2'd0;
            if ((i_q + CW'(1)) == kept_q) begin
              kept_d = '0; recv_d = '0; err_d = scks_pkg::ErrNone;
              state_d = scks_pkg::ST_WAIT;
            end else begin
              i_d = i_q + CW'(1);
            end
          end
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      scks_pkg::ST_WAIT: begin
        if (!out_valid_d) state_d = scks_pkg::ST_LOAD;
      end
      default: state_d = scks_pkg::ST_LOAD;
    endcase
  end

  // when ST_READ follows a move to the front, j is zero: place cur there
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scks_pkg::ST_LOAD; kept_q <= '0; recv_q <= '0; err_q <= '0;
      i_q <= '0; j_q <= '0; ph_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; kept_q <= kept_d; recv_q <= recv_d; err_q <= err_d;
      i_q <= i_d; j_q <= j_d; ph_q <= ph_d; out_valid_q <= out_valid_d;
    end
  end

  // result payload
  logic [5:0] slot_hold_q;
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (state_q == scks_pkg::ST_READ) cur_key_q <= cur_key_d;
    has_q <= out_has_d; first_q <= out_first_d; end_q <= out_end_d;
    chunk_q <= out_chunk_d; oerr_q <= out_err_d; vis_q <= out_vis_d; log_q <= out_log_d;
    slot_sel_q <= slot_sel_d;
    if (out_valid_d && !(out_valid_q && out_stall_i)) slot_hold_q <= 6'(slot_rd_q);
  end

  assign out_valid_o     = out_valid_q;
  assign has_item_o      = has_q;
  assign slot_index_o    = slot_sel_q ? slot_hold_q : 6'd0;
  assign chunk_number_o  = chunk_q;
  assign chunk_first_o   = first_q;
  assign error_code_o    = oerr_q;
  assign visible_total_o = vis_q;
  assign logical_total_o = log_q;
  assign run_end_o       = end_q;

  `include "sprite_cull_and_key_sort_assert.svh"
  `SCKS_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != scks_pkg::ST_LOAD, in_stall_o)
  `SCKS_ASSERT_IMP(a_kept_le_recv, clk_i, rst_ni, 1'b1, kept_q <= recv_q)
  `SCKS_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_valid_q && out_stall_i,
                    out_valid_q && $stable(run_end_o) && $stable(slot_index_o))
endmodule
